// ----- design/rlbe_pkg.sv -----
// rlbe_pkg: types and constants for the rgb led bit encoder
// beat structs, register indexes, reset values and divide-by-100 constants
// no dependencies
`default_nettype none

package rlbe_pkg;

    // input beat: one led
    typedef struct packed {
        logic [7:0] green_in;
        logic [7:0] red_in;
        logic [7:0] blue_in;
        logic       last_led;
    } item_t;

    // output beat: one bit slot or the reset period
    typedef struct packed {
        logic [7:0] duty_code;
        logic       is_reset;
        logic [7:0] reset_length;
        logic       last;
    } result_t;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_LEVEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_CODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_CODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_SLOTS = 3'd5;

    localparam logic [6:0] RST_BRIGHTNESS  = 7'd100;
    localparam logic [6:0] RST_FADE_LEVEL  = 7'd100;
    localparam logic       RST_FADE_ENABLE = 1'b0;
    localparam logic [7:0] RST_ONE_CODE    = 8'd36;
    localparam logic [7:0] RST_ZERO_CODE   = 8'd16;
    localparam logic [7:0] RST_RESET_SLOTS = 8'd120;

    // bit slots per led and slot counter width (also counts the reset slot)
    localparam int unsigned SLOTS_PER_LED = 24;
    localparam int unsigned SLOT_W        = 5;
    localparam logic [SLOT_W-1:0] SLOT_LAST_BIT = 5'd23;
    localparam logic [SLOT_W-1:0] SLOT_RESET    = 5'd24;

    // floor(p/100) == (p*5243)>>19, exact for p below 43690; p never exceeds 255*127
    localparam int unsigned PROD_W     = 15;
    localparam int unsigned RECIP_W    = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int unsigned RECIP_SHIFT = 19;
    localparam int unsigned QUOT_W      = PROD_W + RECIP_W;

endpackage

`default_nettype wire

// ----- design/rgb_led_bit_encoder_core.sv -----
// rgb_led_bit_encoder_core: led colour bytes in, pwm duty code per bit slot out
// depends on rlbe_pkg (beat structs, register indexes, constants)
// an accepted item passes stages 1, 2, 3 and the serialiser before its first bit-slot result beat
// throughput: 24 result beats per led, 25 on the last led of a frame; one
//   beat a cycle while result_ready is high, so the bit serialiser sets the rate
// three pipeline stages (level select, byte * level, divide by 100) may hold
//   further leds while the serialiser is busy; a new item is taken every cycle
//   until they fill
// reset: asynchronous active low, clears valid bits, the serialiser busy flag and
//   slot counter, and restores the configuration registers to their defaults
`default_nettype none

module rgb_led_bit_encoder_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // led channel
    input  wire logic                             item_valid,
    output logic                                  item_ready,
    input  wire rlbe_pkg::item_t                  item,
    // bit-slot channel
    output logic                                  result_valid,
    input  wire logic                             result_ready,
    output rlbe_pkg::result_t                     result,
    // configuration writes
    input  wire logic                             cfg_we,
    input  wire logic [rlbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rlbe_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [6:0] brightness_reg;
    logic [6:0] fade_level_reg;
    logic       fade_enable_reg;
    logic [7:0] one_code_reg;
    logic [7:0] zero_code_reg;
    logic [7:0] reset_slots_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg  <= rlbe_pkg::RST_BRIGHTNESS;
            fade_level_reg  <= rlbe_pkg::RST_FADE_LEVEL;
            fade_enable_reg <= rlbe_pkg::RST_FADE_ENABLE;
            one_code_reg    <= rlbe_pkg::RST_ONE_CODE;
            zero_code_reg   <= rlbe_pkg::RST_ZERO_CODE;
            reset_slots_reg <= rlbe_pkg::RST_RESET_SLOTS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rlbe_pkg::REG_BRIGHTNESS:  brightness_reg  <= cfg_data[6:0];
                rlbe_pkg::REG_FADE_LEVEL:  fade_level_reg  <= cfg_data[6:0];
                rlbe_pkg::REG_FADE_ENABLE: fade_enable_reg <= cfg_data[0];
                rlbe_pkg::REG_ONE_CODE:    one_code_reg    <= cfg_data;
                rlbe_pkg::REG_ZERO_CODE:   zero_code_reg   <= cfg_data;
                rlbe_pkg::REG_RESET_SLOTS: reset_slots_reg <= cfg_data;
                default: ; // unknown index: write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control
    // each stage loads when empty or when its content moves on; the
    // serialiser frees on the final beat of its current led
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic ser_busy_reg;

    logic ser_final;
    logic ser_free;
    logic s3_open;
    logic s2_open;
    logic s1_open;
    logic s1_load;
    logic s2_load;
    logic s3_load;
    logic ser_load;

    assign ser_free   = !ser_busy_reg || (result_ready && ser_final);
    assign s3_open    = !s3_valid_reg || ser_free;
    assign s2_open    = !s2_valid_reg || s3_open;
    assign s1_open    = !s1_valid_reg || s2_open;
    assign item_ready = s1_open;

    assign s1_load  = item_valid && s1_open;
    assign s2_load  = s1_valid_reg && s2_open;
    assign s3_load  = s2_valid_reg && s3_open;
    assign ser_load = s3_valid_reg && ser_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_open)
            begin
                s1_valid_reg <= item_valid;
            end
            if (s2_open)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_open)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: capture the led and pick the percent level
    // ------------------------------------------------------------------
    rlbe_pkg::item_t s1_item_reg;
    logic [6:0]      s1_level_reg;

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_item_reg  <= item;
            s1_level_reg <= fade_enable_reg ? fade_level_reg : brightness_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: byte * level, three small multipliers
    // ------------------------------------------------------------------
    logic [rlbe_pkg::PROD_W-1:0] s2_prod_g_reg;
    logic [rlbe_pkg::PROD_W-1:0] s2_prod_r_reg;
    logic [rlbe_pkg::PROD_W-1:0] s2_prod_b_reg;
    logic                        s2_last_reg;

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_prod_g_reg <= rlbe_pkg::PROD_W'(s1_item_reg.green_in)
                             * rlbe_pkg::PROD_W'(s1_level_reg);
            s2_prod_r_reg <= rlbe_pkg::PROD_W'(s1_item_reg.red_in)
                             * rlbe_pkg::PROD_W'(s1_level_reg);
            s2_prod_b_reg <= rlbe_pkg::PROD_W'(s1_item_reg.blue_in)
                             * rlbe_pkg::PROD_W'(s1_level_reg);
            s2_last_reg   <= s1_item_reg.last_led;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: divide by 100 through the reciprocal, saturate at 255
    // ------------------------------------------------------------------
    logic [rlbe_pkg::QUOT_W-1:0] quot_g;
    logic [rlbe_pkg::QUOT_W-1:0] quot_r;
    logic [rlbe_pkg::QUOT_W-1:0] quot_b;
    logic [7:0]                  scaled_g;
    logic [7:0]                  scaled_r;
    logic [7:0]                  scaled_b;

    assign quot_g = (rlbe_pkg::QUOT_W'(s2_prod_g_reg) * rlbe_pkg::QUOT_W'(rlbe_pkg::RECIP_100))
                    >> rlbe_pkg::RECIP_SHIFT;
    assign quot_r = (rlbe_pkg::QUOT_W'(s2_prod_r_reg) * rlbe_pkg::QUOT_W'(rlbe_pkg::RECIP_100))
                    >> rlbe_pkg::RECIP_SHIFT;
    assign quot_b = (rlbe_pkg::QUOT_W'(s2_prod_b_reg) * rlbe_pkg::QUOT_W'(rlbe_pkg::RECIP_100))
                    >> rlbe_pkg::RECIP_SHIFT;

    // a level above 100 can push the quotient past one byte
    assign scaled_g = (quot_g > rlbe_pkg::QUOT_W'(255)) ? 8'hFF : quot_g[7:0];
    assign scaled_r = (quot_r > rlbe_pkg::QUOT_W'(255)) ? 8'hFF : quot_r[7:0];
    assign scaled_b = (quot_b > rlbe_pkg::QUOT_W'(255)) ? 8'hFF : quot_b[7:0];

    logic [23:0] s3_word_reg;
    logic        s3_last_reg;

    always_ff @(posedge clk)
    begin
        if (s3_load)
        begin
            s3_word_reg <= {scaled_g, scaled_r, scaled_b};
            s3_last_reg <= s2_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // bit serialiser: one beat per slot, msb first, green red blue;
    // the slot after the 24th is the reset period on a last led
    // ------------------------------------------------------------------
    logic [23:0]                 ser_word_reg;
    logic [23:0]                 ser_word_next;
    logic                        ser_last_led_reg;
    logic [rlbe_pkg::SLOT_W-1:0] slot_reg;
    logic [rlbe_pkg::SLOT_W-1:0] slot_next;
    logic                        ser_busy_next;
    logic                        is_reset_slot;
    logic                        beat_taken;

    assign is_reset_slot = (slot_reg == rlbe_pkg::SLOT_RESET);
    assign ser_final     = is_reset_slot
                           || (slot_reg == rlbe_pkg::SLOT_LAST_BIT && !ser_last_led_reg);
    assign beat_taken    = ser_busy_reg && result_ready;

    always_comb
    begin
        ser_word_next = ser_word_reg;
        slot_next     = slot_reg;
        ser_busy_next = ser_busy_reg;
        if (ser_load)
        begin
            ser_word_next = s3_word_reg;
            slot_next     = '0;
            ser_busy_next = 1'b1;
        end
        else if (beat_taken)
        begin
            ser_word_next = {ser_word_reg[22:0], 1'b0};
            slot_next     = slot_reg + rlbe_pkg::SLOT_W'(1);
            if (ser_final)
            begin
                ser_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_busy_reg <= 1'b0;
            slot_reg     <= '0;
        end
        else
        begin
            ser_busy_reg <= ser_busy_next;
            slot_reg     <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ser_word_reg <= ser_word_next;
        if (ser_load)
        begin
            ser_last_led_reg <= s3_last_reg;
        end
    end

    // result beat straight from serialiser registers
    assign result_valid = ser_busy_reg;

    always_comb
    begin
        result.is_reset     = is_reset_slot;
        result.last         = ser_final;
        if (is_reset_slot)
        begin
            result.duty_code    = 8'd0;
            result.reset_length = reset_slots_reg;
        end
        else
        begin
            result.duty_code    = ser_word_reg[23] ? one_code_reg : zero_code_reg;
            result.reset_length = 8'd0;
        end
    end

endmodule

`default_nettype wire
